/* sv/pps_pkg.sv */
// Package: task table sizes, channel structs, opcodes and FSM state type.
`default_nettype none
package pps_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] arrival_tick;
        logic [15:0] burst_len;
        logic [7:0]  prio_level;
    } in_item_t;

    typedef struct packed {
        logic [31:0] tick_start;
        logic        busy_res;
        logic [3:0]  slot_run;
        logic        first_run;
        logic [31:0] response_ticks;
        logic        finished;
        logic [31:0] turnaround_ticks;
        logic [31:0] waiting_ticks;
    } out_item_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage
`default_nettype wire

/* sv/preemptive_priority_scheduler_unit.sv */
// Top level: tick-driven preemptive priority scheduler over a task table in RAM.
// Usage:
//   Input channel: drive item and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low.
//   A load transaction (op = load) writes the task into the next free slot in
//   that same edge and leaves busy low; loads beyond MAX_TASKS are dropped.
//   A tick transaction scans the loaded slots, one RAM read per cycle, picks
//   the most urgent arrived task, writes its remaining work back and reports.
//   A tick passes through the scan state and then the done state with busy high;
//   done is registered and rises as busy falls back to idle. The scan reads each
//   loaded slot in turn over the single RAM read port.
//   Output channel: result holds one transaction until the next, marked by done
//   for exactly one cycle. The receiver cannot stall; done is never high on
//   consecutive cycles. A new transaction may be accepted in the cycle done is high.
//   Reset (rst_n low, asynchronous) empties the table, clears the started
//   flags and sets the tick counter to zero; task RAM contents are not cleared.
`default_nettype none
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  item,
    output logic           done,
    output out_item_t      result
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;
    logic [16:0]          best_ab_reg, best_ab_next;
    logic [31:0]          tick_reg, tick_next;
    logic [31:0]          tick_inc_reg, tick_inc_next;
    logic [MAX_TASKS-1:0] started_reg, started_next;
    out_item_t            result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               wr_entry;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    logic                 accept;
    logic                 issuing;
    logic                 eligible;
    logic                 better;

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign issuing  = (issue_reg < count_reg);
    assign eligible = ({16'd0, rd_entry.arrival} <= tick_reg) && (rd_entry.remaining != 16'd0);
    assign better   = !have_reg || (rd_entry.prio < best_reg.prio) ||
                      ((rd_entry.prio == best_reg.prio) && (rd_entry.arrival < best_reg.arrival));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        best_ab_next  = best_ab_reg;
        tick_next     = tick_reg;
        tick_inc_next = tick_inc_reg;
        started_next  = started_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        wr_entry      = best_reg;
        ram_re        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        if (count_reg < CNT_W'(MAX_TASKS))
                        begin
                            ram_we                                = 1'b1;
                            wr_entry.arrival                      = item.arrival_tick;
                            wr_entry.burst                        = item.burst_len;
                            wr_entry.prio                         = item.prio_level;
                            wr_entry.remaining                    = item.burst_len;
                            started_next[count_reg[IDX_W-1:0]]    = 1'b0;
                            count_next                            = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next    = ST_SCAN;
                        issue_next    = '0;
                        have_next     = 1'b0;
                        tick_inc_next = tick_reg + 32'd1;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_re        = issuing;
                pend_next     = issuing;
                pend_idx_next = issue_reg[IDX_W-1:0];
                if (issuing)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_reg && eligible && better)
                begin
                    have_next     = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = rd_entry;
                    best_ab_next  = {1'b0, rd_entry.arrival} + {1'b0, rd_entry.burst};
                end
                if (!issuing)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                result_next            = '0;
                result_next.tick_start = tick_reg;
                if (have_reg)
                begin
                    result_next.busy_res = 1'b1;
                    result_next.slot_run = 4'(best_idx_reg);
                    if (!started_reg[best_idx_reg])
                    begin
                        result_next.first_run      = 1'b1;
                        result_next.response_ticks = tick_reg - {16'd0, best_reg.arrival};
                    end
                    if (best_reg.remaining == 16'd1)
                    begin
                        result_next.finished         = 1'b1;
                        result_next.turnaround_ticks = tick_inc_reg - {16'd0, best_reg.arrival};
                        result_next.waiting_ticks    = tick_inc_reg - {15'd0, best_ab_reg};
                    end
                    ram_we                     = 1'b1;
                    ram_waddr                  = best_idx_reg;
                    wr_entry.remaining         = best_reg.remaining - 16'd1;
                    started_next[best_idx_reg] = 1'b1;
                end
                done_next  = 1'b1;
                tick_next  = tick_inc_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            have_reg    <= 1'b0;
            tick_reg    <= '0;
            started_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            have_reg    <= have_next;
            tick_reg    <= tick_next;
            started_reg <= started_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_ab_reg  <= best_ab_next;
        tick_inc_reg <= tick_inc_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* sv/pps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* sv/pps_checker.sv */
// Port-level checker for the scheduler top level, with its bind statement.
`default_nettype none
module pps_checker
    import pps_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire in_item_t  item,
    input wire logic      done,
    input wire out_item_t result
);

    ap_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high on two consecutive cycles");

    ap_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_TICK) |=> busy)
        else $error("tick transaction did not raise busy");

    ap_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_LOAD) |=> (!busy && !done))
        else $error("load transaction caused busy or a result");

    ap_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("tick ended without a result");

    ap_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.busy_res) |->
            (!result.first_run && !result.finished && result.slot_run == 4'd0))
        else $error("idle result carries task fields");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
`default_nettype wire
